### hw/rtl/tpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int ID_W  = 37;
  localparam int AGE_W = 8;
  localparam int POS_W = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic             urg;
  } entry_t;

  localparam entry_t ENTRY_NONE = '0;

  typedef struct packed {
    logic             ins_go;
    logic             rem_go;
    logic             urg;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } op_t;

  typedef struct packed {
    logic ahead;
    logic later;
    logic ins_here;
    logic rem_here;
  } cell_stat_t;

endpackage
`default_nettype wire

### hw/rtl/two_class_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-class priority queue built as a chain of entry cells, slot 0 at the
// front. The request is registered when accepted, and in the next cycle
// the whole cell chain finds the slot and shifts in one step. busy is
// high for that one cycle; done then marks the result for exactly one
// cycle and a new request may be started in that same cycle. The receiver
// cannot stall: sample the result ports whenever done is high. head_*
// always show the current front entry.
module two_class_priority_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      req_type,
  input  wire logic [tpq_pkg::KEY_W-1:0] patient_key,
  input  wire logic [tpq_pkg::ID_W-1:0]  record_id,
  input  wire logic [tpq_pkg::AGE_W-1:0] age,
  input  wire logic                      urgent,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [tpq_pkg::POS_W-1:0]      position,
  output logic [tpq_pkg::POS_W-1:0]      occupancy,
  output logic [tpq_pkg::KEY_W-1:0]      head_key,
  output logic [tpq_pkg::ID_W-1:0]       head_record_id,
  output logic                           head_urgent
);
  import tpq_pkg::*;

  fsm_t             state;
  fsm_t             state_next;
  logic             accept;
  logic             req_kind;
  logic [KEY_W-1:0] req_key;
  logic [ID_W-1:0]  req_id;
  logic [AGE_W-1:0] req_age;
  logic             req_urg;
  logic [CNT_W-1:0] count;
  op_t              op;
  entry_t           ents [DEPTH];
  cell_stat_t       stats [DEPTH];
  logic             full;
  logic             found;
  logic [CNT_W-1:0] ins_pos;
  logic [CNT_W-1:0] rem_pos;

  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req_type;
      req_key  <= patient_key;
      req_id   <= record_id;
      req_age  <= age;
      req_urg  <= urgent;
    end
  end

  assign full  = ents[DEPTH-1].valid;
  assign found = stats[0].later;

  always_comb begin
    op.ins_go = (state == S_EXEC) && (req_kind == REQ_INSERT) && !full;
    op.rem_go = (state == S_EXEC) && (req_kind == REQ_REMOVE) && found;
    op.urg    = req_urg;
    op.key    = req_key;
    op.id     = req_id;
    op.age    = req_age;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   a_in;
    logic   l_in;

    if (g == 0) begin : g_first
      assign prev_e = ENTRY_NONE;
      assign a_in   = 1'b0;
    end else begin : g_mid_prev
      assign prev_e = ents[g-1];
      assign a_in   = stats[g-1].ahead;
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_e = ENTRY_NONE;
      assign l_in   = 1'b0;
    end else begin : g_mid_next
      assign next_e = ents[g+1];
      assign l_in   = stats[g+1].later;
    end

    tpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .ahead_in (a_in),
      .later_in (l_in),
      .ent      (ents[g]),
      .stat     (stats[g])
    );
  end

  // one-hot slot marks to index
  always_comb begin
    ins_pos = '0;
    rem_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stats[i].ins_here) begin
        ins_pos = ins_pos | CNT_W'(i);
      end
      if (stats[i].rem_here) begin
        rem_pos = rem_pos | CNT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      if (op.ins_go) begin
        count <= count + CNT_W'(1);
      end else if (op.rem_go) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      if (req_kind == REQ_INSERT) begin
        status   <= full ? ST_FULL : ST_DONE;
        position <= full ? '0 : POS_W'(ins_pos);
      end else begin
        status   <= found ? ST_DONE : ST_MISSING;
        position <= found ? POS_W'(rem_pos) : '0;
      end
    end
  end

  assign occupancy      = POS_W'(count);
  assign head_key       = ents[0].valid ? ents[0].key : '0;
  assign head_record_id = ents[0].valid ? ents[0].id : '0;
  assign head_urgent    = ents[0].valid ? ents[0].urg : 1'b0;

endmodule
`default_nettype wire

### hw/rtl/tpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tpq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tpq_pkg::op_t       op,
  input  wire tpq_pkg::entry_t    prev_ent,
  input  wire tpq_pkg::entry_t    next_ent,
  input  wire logic               ahead_in,
  input  wire logic               later_in,
  output tpq_pkg::entry_t         ent,
  output tpq_pkg::cell_stat_t     stat
);
  import tpq_pkg::*;

  logic   at_point;
  logic   match;
  entry_t new_ent;

  assign at_point = op.urg ? !(ent.valid && ent.urg) : !ent.valid;
  assign match    = ent.valid && (ent.key == op.key);

  assign stat.ahead    = ahead_in | at_point;
  assign stat.later    = later_in | match;
  assign stat.ins_here = at_point && !ahead_in;
  assign stat.rem_here = match && !later_in;

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.key   = op.key;
    new_ent.id    = op.id;
    new_ent.age   = op.age;
    new_ent.urg   = op.urg;
  end

  // valid bit is control, payload is not reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (op.ins_go) begin
      if (ahead_in) begin
        ent <= prev_ent;
      end else if (at_point) begin
        ent <= new_ent;
      end
    end else if (op.rem_go && !later_in) begin
      ent <= next_ent;
    end
  end

endmodule
`default_nettype wire
